// ===== rtl/drs_pkg.sv =====
// shared types, permutation tables and helper functions for the des round subkey pipeline
// no dependencies; used by every stage module and the top level
package drs_pkg;

  localparam int KEY_W      = 64;
  localparam int ROUND_W    = 5;
  localparam int HALF_W     = 28;
  localparam int CD_W       = 2 * HALF_W;
  localparam int SUBKEY_W   = 48;
  localparam int ROT_W      = 5;
  localparam int NUM_ROUNDS = 16;
  localparam int POS_W      = 7;
  localparam int S_DATA_W   = ((KEY_W + ROUND_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((SUBKEY_W + 7) / 8) * 8;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [ROUND_W-1:0]  round_t;
  typedef logic [HALF_W-1:0]   half_t;
  typedef logic [ROT_W-1:0]    rot_t;
  typedef logic [SUBKEY_W-1:0] subkey_t;
  typedef logic [POS_W-1:0]    pos_t;

  // key halves after pc-1 with the rotation still to apply
  typedef struct packed {
    half_t c;
    half_t d;
    rot_t  rot;
  } halves_t;

  // pc-1: entry j gives the key bit (1 = msb) for output bit j (msb first)
  localparam pos_t PC1_TAB [CD_W] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  // pc-2: entry j gives the joined c/d bit (1 = msb) for subkey bit j
  localparam pos_t PC2_TAB [SUBKEY_W] = '{
    7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,
    7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
    7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,
    7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
    7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
    7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
    7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53,
    7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
  };

  // running total of the shift schedule per round, modulo the half width
  // (sixteen rounds add up to a full turn, so the last entry is zero)
  localparam rot_t ROT_TAB [NUM_ROUNDS+1] = '{
    5'd0,  5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd0
  };

  function automatic logic [CD_W-1:0] pc1(key_t key);
    logic [CD_W-1:0] res;
    res = '0;
    for (int j = 0; j < CD_W; j++) begin
      res[CD_W-1-j] = key[KEY_W - int'(PC1_TAB[j])];
    end
    return res;
  endfunction

  function automatic subkey_t pc2(logic [CD_W-1:0] cd);
    subkey_t res;
    res = '0;
    for (int j = 0; j < SUBKEY_W; j++) begin
      res[SUBKEY_W-1-j] = cd[CD_W - int'(PC2_TAB[j])];
    end
    return res;
  endfunction

  // rounds past the last one saturate to the full schedule
  function automatic rot_t rot_amount(round_t rnd);
    rot_t res;
    if (rnd > round_t'(NUM_ROUNDS)) begin
      res = ROT_TAB[NUM_ROUNDS];
    end else begin
      res = ROT_TAB[rnd];
    end
    return res;
  endfunction

  function automatic half_t rotl(half_t h, rot_t s);
    logic [2*HALF_W-1:0] w;
    w = {h, h} << s;
    return w[2*HALF_W-1:HALF_W];
  endfunction

endpackage

// ===== rtl/des_round_subkey.sv =====
// DES round subkey generator: a key and a round number in, that round's 48-bit subkey out.
// The pipeline has three register stages (pc-1 with rotation lookup, half rotation, pc-2
// into the output register); an accepted word passes through all three before its
// subkey is presented, and a new word is taken every cycle unless the output is held. When
// the output word is held by a low m_tready, all stages hold together and s_tready drops until
// the output is taken. Rounds above sixteen act as round sixteen, which equals round zero; key
// parity bits are ignored.
// depends on drs_pkg, drs_select, drs_rotate, drs_compress
module des_round_subkey (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [drs_pkg::S_DATA_W-1:0] s_tdata,   // key [63:0], round [68:64], zero pad
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [drs_pkg::M_DATA_W-1:0] m_tdata    // subkey [47:0]
);
  import drs_pkg::*;

  logic    advance;
  key_t    key;
  round_t  round;
  logic    sel_valid;
  halves_t halves;
  logic    rot_valid;
  logic [CD_W-1:0] cd;
  subkey_t subkey;

  // whole pipe moves unless a finished word waits at the output
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // unpack the input word
  assign key   = s_tdata[KEY_W-1:0];
  assign round = s_tdata[KEY_W+ROUND_W-1:KEY_W];

  drs_select u_select (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s_tvalid),
    .key       (key),
    .round     (round),
    .out_valid (sel_valid),
    .halves    (halves)
  );

  drs_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (sel_valid),
    .halves    (halves),
    .out_valid (rot_valid),
    .cd        (cd)
  );

  drs_compress u_compress (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (rot_valid),
    .cd        (cd),
    .out_valid (m_tvalid),
    .subkey    (subkey)
  );

  assign m_tdata = M_DATA_W'(subkey);

endmodule

// ===== rtl/drs_select.sv =====
// first stage: pc-1 of the key into two halves and lookup of the total rotation
// depends on drs_pkg
module drs_select (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  drs_pkg::key_t    key,
  input  drs_pkg::round_t  round,
  output logic             out_valid,
  output drs_pkg::halves_t halves
);
  import drs_pkg::*;

  logic [CD_W-1:0] cd;

  assign cd = pc1(key);

  // valid bit follows the word when the pipe moves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // halves and rotation amount
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      halves.c   <= cd[CD_W-1:HALF_W];
      halves.d   <= cd[HALF_W-1:0];
      halves.rot <= rot_amount(round);
    end
  end

endmodule

// ===== rtl/drs_rotate.sv =====
// second stage: left rotation of both key halves by the looked-up amount
// depends on drs_pkg
module drs_rotate (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  drs_pkg::halves_t           halves,
  output logic                       out_valid,
  output logic [drs_pkg::CD_W-1:0]   cd
);
  import drs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // rotate and join, c in the upper half
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      cd <= {rotl(halves.c, halves.rot), rotl(halves.d, halves.rot)};
    end
  end

endmodule

// ===== rtl/drs_compress.sv =====
// third stage: pc-2 of the joined halves into the output register
// depends on drs_pkg
module drs_compress (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [drs_pkg::CD_W-1:0] cd,
  output logic                     out_valid,
  output drs_pkg::subkey_t         subkey
);
  import drs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // subkey selection
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      subkey <= pc2(cd);
    end
  end

endmodule

// ===== tb/sv/drs_subkey_checker.sv =====
// subkey checker: watches the key and subkey streams, predicts each subkey, compares
// depends on drs_pkg for field widths and types; instantiated by tb_des_round_subkey
`timescale 1ns / 100ps

module drs_subkey_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [drs_pkg::S_DATA_W-1:0] s_tdata,   // key [63:0], round [68:64], zero pad
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [drs_pkg::M_DATA_W-1:0] m_tdata,   // subkey [47:0]
  output int                           mismatches,
  output int                           awaiting
);
  import drs_pkg::*;

  // left shifts per round of the standard schedule
  localparam int ROUND_SHIFT [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

  // key bit (1 = msb) feeding each of the 56 c/d bits, msb first
  localparam int KEY_SELECT [56] = '{
    57, 49, 41, 33, 25, 17, 9,  1,  58, 50, 42, 34, 26, 18,
    10, 2,  59, 51, 43, 35, 27, 19, 11, 3,  60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15, 7,  62, 54, 46, 38, 30, 22,
    14, 6,  61, 53, 45, 37, 29, 21, 13, 5,  28, 20, 12, 4
  };

  // c/d bit (1 = msb) feeding each of the 48 subkey bits, msb first
  localparam int SUBKEY_SELECT [48] = '{
    14, 17, 11, 24, 1,  5,  3,  28, 15, 6,  21, 10,
    23, 19, 12, 4,  26, 8,  16, 7,  27, 20, 13, 2,
    41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
    44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
  };

  subkey_t subkeys_due [$];
  subkey_t want;

  // subkey of a key for a round: select, rotate both halves one step at a time, compress
  function automatic subkey_t subkey_of(key_t key, round_t rnd);
    logic [55:0] cd;
    half_t       c;
    half_t       d;
    subkey_t     sk;
    int          last;
    int          steps;
    last  = (rnd > 16) ? 16 : int'(rnd);
    steps = 0;
    for (int i = 0; i < last; i++) begin
      steps += ROUND_SHIFT[i];
    end
    steps = steps % 28;
    for (int j = 0; j < 56; j++) begin
      cd[55-j] = key[64-KEY_SELECT[j]];
    end
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < steps; i++) begin
      c = {c[26:0], c[27]};
      d = {d[26:0], d[27]};
    end
    cd = {c, d};
    for (int j = 0; j < 48; j++) begin
      sk[47-j] = cd[56-SUBKEY_SELECT[j]];
    end
    return sk;
  endfunction

  // record each accepted key word, check each accepted subkey word in order
  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        subkeys_due.push_back(subkey_of(s_tdata[KEY_W-1:0], s_tdata[KEY_W +: ROUND_W]));
      end
      if (m_tvalid && m_tready) begin
        if (subkeys_due.size() == 0) begin
          $display("%0t: unexpected subkey word, expected none, got %012h",
                   $time, m_tdata[SUBKEY_W-1:0]);
          mismatches++;
        end else begin
          want = subkeys_due.pop_front();
          if (m_tdata[SUBKEY_W-1:0] !== want) begin
            $display("%0t: subkey mismatch, expected %012h, got %012h",
                     $time, want, m_tdata[SUBKEY_W-1:0]);
            mismatches++;
          end
        end
      end
    end
    awaiting <= subkeys_due.size();
  end

endmodule

// ===== tb/sv/tb_des_round_subkey.sv =====
// top of the des round subkey testbench: clock, reset, key stimulus, output stalls, verdict
// depends on drs_pkg, des_round_subkey and drs_subkey_checker
`timescale 1ns / 100ps

module tb_des_round_subkey;
  import drs_pkg::*;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;    // key [63:0], round [68:64], zero pad
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;    // subkey [47:0]

  int mismatches;
  int awaiting;
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;

  des_round_subkey dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  drs_subkey_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest correct run
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // output side stalls in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
      stall_left = $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // mostly full random keys, some with a single bit set or cleared
  function automatic key_t pick_key();
    key_t k;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: k = key_t'(1) << $urandom_range(0, KEY_W - 1);
      1: k = ~(key_t'(1) << $urandom_range(0, KEY_W - 1));
      default: ;
    endcase
    return k;
  endfunction

  // real rounds most of the time, out-of-range ones now and then
  function automatic round_t pick_round();
    round_t r;
    if ($urandom_range(0, 3) == 0) begin
      r = round_t'($urandom_range(17, 31));
    end else begin
      r = round_t'($urandom_range(0, 16));
    end
    return r;
  endfunction

  // offer one key word, with an optional idle burst first, and wait for acceptance
  task automatic send_key(input key_t key, input round_t rnd);
    logic [S_DATA_W-1:0] word;
    int                  gap;
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      s_tdata  <= S_DATA_W'({$urandom, $urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[KEY_W-1:0]       = key;
    word[KEY_W +: ROUND_W] = rnd;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin
    int n;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // every round of the textbook key, then extremes, parity bits and saturation
    for (n = 0; n <= 16; n++) begin
      send_key(64'h1334_5779_9BBC_DFF1, round_t'(n));
    end
    send_key(64'h0, 5'd0);
    send_key(64'hFFFF_FFFF_FFFF_FFFF, 5'd16);
    send_key(64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
    send_key(64'h0101_0101_0101_0101, 5'd5);
    send_key(64'hFEFE_FEFE_FEFE_FEFE, 5'd17);
    send_key(64'h8000_0000_0000_0001, 5'd24);

    // hold off until the pipeline has drained
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);

    // random keys: heavy idling, none, light idling, then none to the end
    for (n = 0; n < 400; n++) begin
      if (n < 150) begin
        gap_pct   = 30;
        stall_pct = 30;
      end else if (n < 200) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (n < 320) begin
        gap_pct   = 10;
        stall_pct = 15;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      send_key(pick_key(), pick_round());
    end
    s_tvalid <= 1'b0;

    // drain with a bound, then keep watching for stray words before the verdict
    for (n = 0; n < 10000 && awaiting != 0; n++) @(posedge clk);
    if (awaiting != 0) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      repeat (10) @(posedge clk);
      if (mismatches == 0 && awaiting == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
      $finish;
    end
  end

endmodule
